FILE: hw/rtl/midpoint_ellipse_points_assert.svh
// Assertion macros for the ellipse point generator.
// Both sample on clk and are disabled while rst_n is low.
`ifndef MIDPOINT_ELLIPSE_POINTS_ASSERT_SVH
`define MIDPOINT_ELLIPSE_POINTS_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/mep_pkg.sv
`timescale 1ns / 1ps

package mep_pkg;

  localparam int COORD_BITS_DEF  = 10;
  localparam int RADIUS_BITS_DEF = 10;

  // decision variable, held as 4x the real midpoint decision
  localparam int DEC_BITS      = 48;
  localparam int OUT_BITS      = 12;
  localparam int OUT_DATA_BITS = 4 * OUT_BITS;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // multiply operations, issued in this order
  localparam int MOP_BITS = 4;
  typedef logic [MOP_BITS-1:0] mop_t;
  localparam mop_t MOP_SQX = 4'd0;  // rx * rx
  localparam mop_t MOP_SQY = 4'd1;  // ry * ry
  localparam mop_t MOP_RXY = 4'd2;  // rx^2 * ry
  localparam mop_t MOP_A1  = 4'd3;  // ry^2 * (2x+1)
  localparam mop_t MOP_A2  = 4'd4;  // ... * (2x+1)
  localparam mop_t MOP_B1  = 4'd5;  // rx^2 * (y-1)
  localparam mop_t MOP_B2  = 4'd6;  // ... * (y-1)
  localparam mop_t MOP_C1  = 4'd7;  // rx^2 * ry
  localparam mop_t MOP_C2  = 4'd8;  // ... * ry

  // product width: decision width, or the exact 2*rx^2*ry term if wider
  function automatic int prod_bits(input int radius_bits);
    int w;
    w = 3 * radius_bits + 2;
    return (w > DEC_BITS) ? w : DEC_BITS;
  endfunction

  typedef struct packed {
    logic load;
    logic capture;
    logic mul_go;
    logic mul_wr;
    mop_t op;
    logic adv1;
    logic adv2;
    logic emit;
    logic last;
  } mep_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic enter_r2;
    logic region_two;
    logic y_nz;
    logic out_free;
  } mep_stat_t;

endpackage

FILE: hw/rtl/mep_mul.sv
`timescale 1ns / 1ps

// Shift-and-add multiplier, one multiplier bit per cycle, product mod 2^PROD_BITS.
module mep_mul #(
  parameter int PROD_BITS = 48,
  parameter int MPLR_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 go,
  input  logic [PROD_BITS-1:0] mcand,
  input  logic [MPLR_BITS-1:0] mplier,
  output logic                 busy,
  output logic                 done,
  output logic [PROD_BITS-1:0] prod
);

  localparam int CNT_BITS = $clog2(MPLR_BITS + 1);

  logic [PROD_BITS-1:0] m_r;
  logic [PROD_BITS-1:0] acc_r;
  logic [MPLR_BITS-1:0] q_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic                 run_r;
  logic                 done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CNT_BITS'(1)) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_r   <= mcand;
      q_r   <= mplier;
      acc_r <= '0;
      cnt_r <= CNT_BITS'(MPLR_BITS);
    end else if (run_r) begin
      if (q_r[0]) begin
        acc_r <= acc_r + m_r;
      end
      m_r   <= m_r << 1;
      q_r   <= q_r >> 1;
      cnt_r <= cnt_r - CNT_BITS'(1);
    end
  end

  assign busy = run_r;
  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: hw/rtl/mep_dp.sv
`timescale 1ns / 1ps

// Datapath: held ellipse, offsets, incremental terms, decision, output register.
module mep_dp #(
  parameter int COORD_BITS  = mep_pkg::COORD_BITS_DEF,
  parameter int RADIUS_BITS = mep_pkg::RADIUS_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [COORD_BITS-1:0]             center_x,
  input  logic [COORD_BITS-1:0]             center_y,
  input  logic [RADIUS_BITS-1:0]            radius_x,
  input  logic [RADIUS_BITS-1:0]            radius_y,
  input  mep_pkg::mep_cmd_t                 cmd,
  output mep_pkg::mep_stat_t                stat,
  input  logic                              out_tready,
  output logic                              out_tvalid,
  output logic signed [mep_pkg::OUT_BITS-1:0] right_x,
  output logic signed [mep_pkg::OUT_BITS-1:0] left_x,
  output logic signed [mep_pkg::OUT_BITS-1:0] lower_y,
  output logic signed [mep_pkg::OUT_BITS-1:0] upper_y,
  output logic                              out_last
);

  localparam int OFS_BITS  = RADIUS_BITS + 1;
  localparam int SQ_BITS   = 2 * RADIUS_BITS;
  localparam int PROD_BITS = mep_pkg::prod_bits(RADIUS_BITS);
  localparam int MPLR_BITS = OFS_BITS + 1;
  localparam int DW        = mep_pkg::DEC_BITS;
  localparam int OW        = mep_pkg::OUT_BITS;

  logic [COORD_BITS-1:0]  hcx_r, hcy_r;
  logic [RADIUS_BITS-1:0] rx_r, ry_r;
  logic [SQ_BITS-1:0]     rx2_r, ry2_r;
  logic [OFS_BITS-1:0]    x_r, y_r;
  logic [PROD_BITS-1:0]   px_r, py_r;   // 2*ry^2*x and 2*rx^2*y
  logic [DW-1:0]          d_r;
  logic                   r2_r;
  logic                   use_px_r, use_py_r;
  logic signed [OW-1:0]   cap_rx_r, cap_lx_r, cap_ly_r, cap_uy_r;
  logic signed [OW-1:0]   out_rx_r, out_lx_r, out_ly_r, out_uy_r;
  logic                   last_r;
  logic                   out_valid_r;

  logic [PROD_BITS-1:0]   rx2_w, ry2_w, c_w;
  logic [MPLR_BITS-1:0]   a_w;
  logic [OFS_BITS-1:0]    b_w;
  logic [PROD_BITS-1:0]   mcand;
  logic [MPLR_BITS-1:0]   mplier;
  logic [PROD_BITS-1:0]   prod;
  logic                   mul_busy, mul_done;
  logic                   d_neg, d_pos;

  assign rx2_w = PROD_BITS'(rx2_r);
  assign ry2_w = PROD_BITS'(ry2_r);
  assign c_w   = r2_r ? rx2_w : ry2_w;
  assign a_w   = {x_r, 1'b1};
  // y-1, or its magnitude 1 when y is already zero (only the square is used)
  assign b_w   = (y_r == '0) ? OFS_BITS'(1) : y_r - OFS_BITS'(1);
  assign d_neg = d_r[DW-1];
  assign d_pos = (d_r != '0) && !d_neg;

  always_comb begin
    unique case (cmd.op)
      mep_pkg::MOP_SQX: begin
        mcand  = PROD_BITS'(rx_r);
        mplier = MPLR_BITS'(rx_r);
      end
      mep_pkg::MOP_SQY: begin
        mcand  = PROD_BITS'(ry_r);
        mplier = MPLR_BITS'(ry_r);
      end
      mep_pkg::MOP_RXY: begin
        mcand  = rx2_w;
        mplier = MPLR_BITS'(ry_r);
      end
      mep_pkg::MOP_A1: begin
        mcand  = ry2_w;
        mplier = a_w;
      end
      mep_pkg::MOP_A2: begin
        mcand  = prod;
        mplier = a_w;
      end
      mep_pkg::MOP_B1: begin
        mcand  = rx2_w;
        mplier = MPLR_BITS'(b_w);
      end
      mep_pkg::MOP_B2: begin
        mcand  = prod;
        mplier = MPLR_BITS'(b_w);
      end
      mep_pkg::MOP_C1: begin
        mcand  = rx2_w;
        mplier = MPLR_BITS'(ry_r);
      end
      mep_pkg::MOP_C2: begin
        mcand  = prod;
        mplier = MPLR_BITS'(ry_r);
      end
      default: begin
        mcand  = '0;
        mplier = '0;
      end
    endcase
  end

  mep_mul #(
    .PROD_BITS(PROD_BITS),
    .MPLR_BITS(MPLR_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .mcand (mcand),
    .mplier(mplier),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hcx_r <= center_x;
      hcy_r <= center_y;
      rx_r  <= radius_x;
      ry_r  <= radius_y;
      x_r   <= '0;
      y_r   <= OFS_BITS'(radius_y);
      r2_r  <= 1'b0;
    end

    if (cmd.capture) begin
      cap_rx_r <= OW'(hcx_r) + OW'(x_r);
      cap_lx_r <= OW'(hcx_r) - OW'(x_r);
      cap_ly_r <= OW'(hcy_r) + OW'(y_r);
      cap_uy_r <= OW'(hcy_r) - OW'(y_r);
    end

    if (cmd.mul_wr) begin
      case (cmd.op)
        mep_pkg::MOP_SQX: rx2_r <= prod[SQ_BITS-1:0];
        mep_pkg::MOP_SQY: ry2_r <= prod[SQ_BITS-1:0];
        mep_pkg::MOP_RXY: begin
          // region one start: 4ry^2 - 4rx^2*ry + rx^2
          d_r  <= DW'(ry2_w << 2) - DW'(prod << 2) + DW'(rx2_w);
          px_r <= '0;
          py_r <= prod << 1;
        end
        mep_pkg::MOP_A2: d_r <= DW'(prod);
        mep_pkg::MOP_B2: d_r <= d_r + DW'(prod << 2);
        mep_pkg::MOP_C2: begin
          d_r  <= d_r - DW'(prod << 2);
          r2_r <= 1'b1;
        end
        default: ;
      endcase
    end

    // step, first half: offsets and incremental terms, pick decision terms
    if (cmd.adv1) begin
      if (!r2_r) begin
        x_r      <= x_r + OFS_BITS'(1);
        px_r     <= px_r + (ry2_w << 1);
        use_px_r <= 1'b1;
        use_py_r <= !d_neg;
        if (!d_neg) begin
          y_r  <= y_r - OFS_BITS'(1);
          py_r <= py_r - (rx2_w << 1);
        end
      end else begin
        y_r      <= y_r - OFS_BITS'(1);
        py_r     <= py_r - (rx2_w << 1);
        use_py_r <= 1'b1;
        use_px_r <= !d_pos;
        if (!d_pos) begin
          x_r  <= x_r + OFS_BITS'(1);
          px_r <= px_r + (ry2_w << 1);
        end
      end
    end

    // step, second half: decision update from the new terms
    if (cmd.adv2) begin
      d_r <= d_r + (use_px_r ? DW'(px_r << 2) : DW'(0)) + DW'(c_w << 2)
                 - (use_py_r ? DW'(py_r << 2) : DW'(0));
    end

    if (cmd.emit) begin
      out_rx_r <= cap_rx_r;
      out_lx_r <= cap_lx_r;
      out_ly_r <= cap_ly_r;
      out_uy_r <= cap_uy_r;
      last_r   <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_comb begin
    stat.mul_busy   = mul_busy;
    stat.mul_done   = mul_done;
    stat.enter_r2   = !r2_r && !(px_r < py_r);
    stat.region_two = r2_r;
    stat.y_nz       = (y_r != '0);
    stat.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign right_x    = out_rx_r;
  assign left_x     = out_lx_r;
  assign lower_y    = out_ly_r;
  assign upper_y    = out_uy_r;
  assign out_last   = last_r;

endmodule

FILE: hw/rtl/mep_ctrl.sv
`timescale 1ns / 1ps

// Sequencer: start set-up, step, region-two switch-over, result hand-off.
module mep_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  input  logic               in_kind,
  output logic               in_tready,
  input  mep_pkg::mep_stat_t stat,
  output mep_pkg::mep_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MGO    = 3'd1;
  localparam logic [2:0] S_MWAIT  = 3'd2;
  localparam logic [2:0] S_ADV1   = 3'd3;
  localparam logic [2:0] S_ADV2   = 3'd4;
  localparam logic [2:0] S_SETTLE = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  mep_pkg::mop_t op_r, op_nxt;
  logic          pend_r, pend_nxt;   // a point of the current ellipse is due
  logic          step_r, step_nxt;   // current work came from a step item

  always_comb begin
    cmd       = '0;
    cmd.op    = op_r;
    state_nxt = state_r;
    op_nxt    = op_r;
    pend_nxt  = pend_r;
    step_nxt  = step_r;
    in_tready = (state_r == S_IDLE);

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_kind == mep_pkg::KIND_START) begin
            cmd.load  = 1'b1;
            op_nxt    = mep_pkg::MOP_SQX;
            pend_nxt  = 1'b0;
            step_nxt  = 1'b0;
            state_nxt = S_MGO;
          end else if (pend_r) begin
            cmd.capture = 1'b1;
            step_nxt    = 1'b1;
            state_nxt   = S_ADV1;
          end
        end
      end
      S_MGO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          cmd.mul_wr = 1'b1;
          if (op_r == mep_pkg::MOP_RXY || op_r == mep_pkg::MOP_C2) begin
            state_nxt = S_SETTLE;
          end else begin
            op_nxt    = op_r + mep_pkg::MOP_BITS'(1);
            state_nxt = S_MGO;
          end
        end
      end
      S_ADV1: begin
        cmd.adv1  = 1'b1;
        state_nxt = S_ADV2;
      end
      S_ADV2: begin
        cmd.adv2  = 1'b1;
        state_nxt = S_SETTLE;
      end
      S_SETTLE: begin
        if (stat.enter_r2) begin
          op_nxt    = mep_pkg::MOP_A1;
          state_nxt = S_MGO;
        end else begin
          pend_nxt  = stat.region_two ? stat.y_nz : 1'b1;
          state_nxt = step_r ? S_EMIT : S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          cmd.last  = !pend_r;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= mep_pkg::MOP_SQX;
      pend_r  <= 1'b0;
      step_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      pend_r  <= pend_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

FILE: hw/rtl/midpoint_ellipse_points.sv
`timescale 1ns / 1ps
// Midpoint ellipse point generator.
// Input channel (in_*): one item per handshake. in_tuser = kind: start latches
// the centre and radii and prepares the first point (no result); step asks for
// the next point. A step with no point left is taken and gives nothing.
// Output channel (out_*): one item per step with the four symmetric
// coordinates; out_tlast marks the final point of the ellipse.
// Timing, with every multiply run on the serial multiplier:
//   start : 3 multiplies, then the settle state, before in_tready returns;
//           6 more multiplies when either radius is zero (first point in region two).
//   step  : the item is taken in S_IDLE and runs through S_ADV1, S_ADV2,
//           S_SETTLE and S_EMIT, where the result is registered; in_tready
//           returns after that, so no new step is taken while one is in work.
//           The step that crosses into region two adds 6 multiplies.
// The result register lets a new item in while a result waits; if the
// receiver stalls, the next step's result is held until out_tready frees it.
// Reset: nothing pending, output empty; steps are ignored until a start.
module midpoint_ellipse_points #(
  parameter int  COORD_BITS  = mep_pkg::COORD_BITS_DEF,
  parameter int  RADIUS_BITS = mep_pkg::RADIUS_BITS_DEF,
  localparam int IN_BITS     = ((2 * COORD_BITS + 2 * RADIUS_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // center_x, center_y, radius_x, radius_y, zero pad
  input  logic [IN_BITS-1:0]                in_tdata,
  // kind
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // right_x, left_x, lower_y, upper_y (12 bits each, signed)
  output logic [mep_pkg::OUT_DATA_BITS-1:0] out_tdata,
  output logic                              out_tlast
);

  localparam int OW = mep_pkg::OUT_BITS;

  mep_pkg::mep_cmd_t  cmd;
  mep_pkg::mep_stat_t status;

  logic [COORD_BITS-1:0]  center_x, center_y;
  logic [RADIUS_BITS-1:0] radius_x, radius_y;
  logic signed [OW-1:0]   right_x, left_x, lower_y, upper_y;

  // unpack the item, first field lowest
  assign center_x = in_tdata[COORD_BITS-1:0];
  assign center_y = in_tdata[2*COORD_BITS-1:COORD_BITS];
  assign radius_x = in_tdata[2*COORD_BITS+RADIUS_BITS-1:2*COORD_BITS];
  assign radius_y = in_tdata[2*COORD_BITS+2*RADIUS_BITS-1:2*COORD_BITS+RADIUS_BITS];

  mep_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_kind  (in_tuser),
    .in_tready(in_tready),
    .stat     (status),
    .cmd      (cmd)
  );

  mep_dp #(
    .COORD_BITS (COORD_BITS),
    .RADIUS_BITS(RADIUS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .center_x  (center_x),
    .center_y  (center_y),
    .radius_x  (radius_x),
    .radius_y  (radius_y),
    .cmd       (cmd),
    .stat      (status),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .right_x   (right_x),
    .left_x    (left_x),
    .lower_y   (lower_y),
    .upper_y   (upper_y),
    .out_last  (out_tlast)
  );

  assign out_tdata = {upper_y, lower_y, left_x, right_x};

`include "midpoint_ellipse_points_assert.svh"

  // a result is only loaded into a free (or draining) output register
  `MEP_ASSERT_IMP(a_emit_free, cmd.emit, status.out_free, "result overwritten while held")
  // the multiplier is never restarted mid-run
  `MEP_ASSERT_IMP(a_mul_idle, cmd.mul_go, !status.mul_busy, "multiply restarted mid-run")
  // no item taken while a multiply is still in flight
  `MEP_ASSERT_IMP(a_take_idle, in_tvalid && in_tready, !status.mul_busy,
                  "item taken during multiply")
  // a loaded result shows on the port next cycle
  `MEP_ASSERT_NXT(a_emit_shows, cmd.emit, out_tvalid, "loaded result not presented")

endmodule
